>>> rtl/core/lcdseq_pkg.sv
// Shared types, codes and helper functions of the character LCD expander sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

  // Result queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAW    = $clog2(QDepth);
  localparam int unsigned QCW    = $clog2(QDepth + 1);

  // Input opcodes.
  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_BL   = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_SEND      = 3'd0;
  localparam logic [2:0] ACT_DELAY     = 3'd1;
  localparam logic [2:0] ACT_INIT_DONE = 3'd2;
  localparam logic [2:0] ACT_CHAR_DONE = 3'd3;
  localparam logic [2:0] ACT_BL_ACK    = 3'd4;
  localparam logic [2:0] ACT_REJECT    = 3'd5;

  // Nibble write phases.
  localparam logic [2:0] PH_NIL       = 3'd0;
  localparam logic [2:0] PH_NIBBLE    = 3'd1;
  localparam logic [2:0] PH_EN_HIGH   = 3'd2;
  localparam logic [2:0] PH_HIGH_HOLD = 3'd3;
  localparam logic [2:0] PH_EN_LOW    = 3'd4;
  localparam logic [2:0] PH_LOW_HOLD  = 3'd5;

  // Expander control lines and masks.
  localparam logic [7:0]  CTL_RS        = 8'h01;
  localparam logic [7:0]  CTL_EN        = 8'h04;
  localparam logic [7:0]  CTL_BL        = 8'h08;
  localparam logic [7:0]  NIB_MASK      = 8'hF0;
  localparam logic [15:0] THIRD_WAIT_MS = 16'd1;

  // Display commands.
  localparam logic [7:0] CMD_WAKE     = 8'h03;
  localparam logic [7:0] CMD_4BIT     = 8'h02;
  localparam logic [7:0] CMD_FUNC     = 8'h20;
  localparam logic [7:0] CMD_DISP     = 8'h08;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h04;
  localparam logic [7:0] CMD_HOME     = 8'h02;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INIT_DLY   = 3'd0;
  localparam logic [2:0] CFG_BL_DLY     = 3'd1;
  localparam logic [2:0] CFG_RETRY_DLY  = 3'd2;
  localparam logic [2:0] CFG_CLR_DLY    = 3'd3;
  localparam logic [2:0] CFG_HOLD_DLY   = 3'd4;
  localparam logic [2:0] CFG_FUNC_FLAGS = 3'd5;
  localparam logic [2:0] CFG_DISP_FLAGS = 3'd6;
  localparam logic [2:0] CFG_ENTRY_FLAGS = 3'd7;

  // Configuration reset values.
  localparam logic [15:0] RST_INIT_DLY    = 16'd50;
  localparam logic [15:0] RST_BL_DLY      = 16'd1000;
  localparam logic [15:0] RST_RETRY_DLY   = 16'd5;
  localparam logic [15:0] RST_CLR_DLY     = 16'd2000;
  localparam logic [15:0] RST_HOLD_DLY    = 16'd1;
  localparam logic [4:0]  RST_FUNC_FLAGS  = 5'd8;
  localparam logic [2:0]  RST_DISP_FLAGS  = 3'd4;
  localparam logic [1:0]  RST_ENTRY_FLAGS = 2'd2;

  typedef struct packed {
    logic [15:0] init_dly;
    logic [15:0] bl_dly;
    logic [15:0] retry_dly;
    logic [15:0] clr_dly;
    logic [15:0] hold_dly;
    logic [4:0]  func_flags;
    logic [2:0]  disp_flags;
    logic [1:0]  entry_flags;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  xbyte;
    logic [15:0] delay_ms;
    logic        last;
  } result_t;

  // Data nibble placed in bits 7..4: high nibble on the first pass of a
  // two-pass byte, low nibble otherwise.
  function automatic logic [7:0] nibble(input logic [7:0] b, input logic two);
    logic [7:0] v;
    v = two ? (b & NIB_MASK) : ({b[3:0], 4'h0} & NIB_MASK);
    return v;
  endfunction

  function automatic logic [7:0] ctl_byte(input logic [7:0] v, input logic bl,
                                          input logic rs);
    logic [7:0] b;
    b = v | (bl ? CTL_BL : 8'h00) | (rs ? CTL_RS : 8'h00);
    return b;
  endfunction

  function automatic result_t mk_res(input logic [2:0] act, input logic [7:0] b,
                                     input logic [15:0] d);
    result_t r;
    r.action   = act;
    r.xbyte    = b;
    r.delay_ms = d;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcdseq_cfg.sv
// Configuration register bank of the character LCD expander sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_cfg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [15:0]         cfg_wdata,
  output lcdseq_pkg::cfg_t    cfg
);

  lcdseq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_dly    <= lcdseq_pkg::RST_INIT_DLY;
      cfg_r.bl_dly      <= lcdseq_pkg::RST_BL_DLY;
      cfg_r.retry_dly   <= lcdseq_pkg::RST_RETRY_DLY;
      cfg_r.clr_dly     <= lcdseq_pkg::RST_CLR_DLY;
      cfg_r.hold_dly    <= lcdseq_pkg::RST_HOLD_DLY;
      cfg_r.func_flags  <= lcdseq_pkg::RST_FUNC_FLAGS;
      cfg_r.disp_flags  <= lcdseq_pkg::RST_DISP_FLAGS;
      cfg_r.entry_flags <= lcdseq_pkg::RST_ENTRY_FLAGS;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdseq_pkg::CFG_INIT_DLY:    cfg_r.init_dly    <= cfg_wdata;
        lcdseq_pkg::CFG_BL_DLY:      cfg_r.bl_dly      <= cfg_wdata;
        lcdseq_pkg::CFG_RETRY_DLY:   cfg_r.retry_dly   <= cfg_wdata;
        lcdseq_pkg::CFG_CLR_DLY:     cfg_r.clr_dly     <= cfg_wdata;
        lcdseq_pkg::CFG_HOLD_DLY:    cfg_r.hold_dly    <= cfg_wdata;
        lcdseq_pkg::CFG_FUNC_FLAGS:  cfg_r.func_flags  <= cfg_wdata[4:0];
        lcdseq_pkg::CFG_DISP_FLAGS:  cfg_r.disp_flags  <= cfg_wdata[2:0];
        lcdseq_pkg::CFG_ENTRY_FLAGS: cfg_r.entry_flags <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/lcdseq_core.sv
// Sequencer state and next-action logic for one accepted beat.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_core (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_fire,
  input  wire  [1:0]             opcode,
  input  wire  [7:0]             char_code,
  input  wire                    backlight_on,
  input  wire lcdseq_pkg::cfg_t  cfg,
  output logic [1:0]             res_cnt,
  output lcdseq_pkg::result_t    res0,
  output lcdseq_pkg::result_t    res1
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_INIT_WAIT  = 5'd1;
  localparam logic [4:0] S_BL_SENT    = 5'd2;
  localparam logic [4:0] S_BL_WAIT    = 5'd3;
  localparam logic [4:0] S_TRY1       = 5'd4;
  localparam logic [4:0] S_TRY1_WAIT  = 5'd5;
  localparam logic [4:0] S_TRY2       = 5'd6;
  localparam logic [4:0] S_TRY2_WAIT  = 5'd7;
  localparam logic [4:0] S_TRY3       = 5'd8;
  localparam logic [4:0] S_TRY3_WAIT  = 5'd9;
  localparam logic [4:0] S_TO4BIT     = 5'd10;
  localparam logic [4:0] S_FUNC       = 5'd11;
  localparam logic [4:0] S_DISP       = 5'd12;
  localparam logic [4:0] S_CLEAR      = 5'd13;
  localparam logic [4:0] S_CLEAR_WAIT = 5'd14;
  localparam logic [4:0] S_ENTRY      = 5'd15;
  localparam logic [4:0] S_HOME       = 5'd16;
  localparam logic [4:0] S_HOME_WAIT  = 5'd17;
  localparam logic [4:0] S_CHAR       = 5'd18;

  logic [4:0] seq_r, seq_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       two_r, two_nxt;
  logic [7:0] btw_r, btw_nxt;
  logic       rs_r, rs_nxt;
  logic       init_r, init_nxt;
  logic       bl_r, bl_nxt;
  logic       pv_r, pv_nxt;
  logic [7:0] pc_r, pc_nxt;

  logic       sw;
  logic       sw_sec;
  logic [7:0] sw_b;
  logic       sw_rs;
  logic       sw_two;
  logic [7:0] nib_v;
  lcdseq_pkg::result_t sres;

  always_comb begin
    seq_nxt  = seq_r;
    ph_nxt   = ph_r;
    two_nxt  = two_r;
    btw_nxt  = btw_r;
    rs_nxt   = rs_r;
    init_nxt = init_r;
    bl_nxt   = bl_r;
    pv_nxt   = pv_r;
    pc_nxt   = pc_r;
    res0     = '0;
    res1     = '0;
    res_cnt  = 2'd0;
    sw       = 1'b0;
    sw_sec   = 1'b0;
    sw_b     = 8'h00;
    sw_rs    = 1'b0;
    sw_two   = 1'b0;
    sres     = '0;
    nib_v    = lcdseq_pkg::nibble(btw_r, two_r);

    if (in_fire) begin
      case (opcode)
        lcdseq_pkg::OP_STEP: begin
          if (ph_r != lcdseq_pkg::PH_NIL) begin
            case (ph_r)
              lcdseq_pkg::PH_NIBBLE: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_SEND,
                            lcdseq_pkg::ctl_byte(nib_v, bl_r, rs_r), 16'd0);
                res_cnt = 2'd1;
                ph_nxt  = lcdseq_pkg::PH_EN_HIGH;
              end
              lcdseq_pkg::PH_EN_HIGH: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_SEND,
                            lcdseq_pkg::ctl_byte(nib_v | lcdseq_pkg::CTL_EN, bl_r, rs_r),
                            16'd0);
                res_cnt = 2'd1;
                ph_nxt  = lcdseq_pkg::PH_HIGH_HOLD;
              end
              lcdseq_pkg::PH_HIGH_HOLD: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.hold_dly);
                res_cnt = 2'd1;
                ph_nxt  = lcdseq_pkg::PH_EN_LOW;
              end
              lcdseq_pkg::PH_EN_LOW: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_SEND,
                            lcdseq_pkg::ctl_byte(nib_v, bl_r, rs_r), 16'd0);
                res_cnt = 2'd1;
                ph_nxt  = lcdseq_pkg::PH_LOW_HOLD;
              end
              lcdseq_pkg::PH_LOW_HOLD: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.hold_dly);
                res_cnt = 2'd1;
                ph_nxt  = two_r ? lcdseq_pkg::PH_NIBBLE : lcdseq_pkg::PH_NIL;
                two_nxt = 1'b0;
              end
              default: ph_nxt = lcdseq_pkg::PH_NIL;
            endcase
          end else if (seq_r != S_IDLE) begin
            case (seq_r)
              S_INIT_WAIT: begin
                bl_nxt  = 1'b1;
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_SEND,
                            lcdseq_pkg::ctl_byte(8'h00, 1'b1, rs_r), 16'd0);
                res_cnt = 2'd1;
                seq_nxt = S_BL_SENT;
              end
              S_BL_SENT: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.bl_dly);
                res_cnt = 2'd1;
                seq_nxt = S_BL_WAIT;
              end
              S_BL_WAIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_WAKE;
                seq_nxt = S_TRY1;
              end
              S_TRY1: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.retry_dly);
                res_cnt = 2'd1;
                seq_nxt = S_TRY1_WAIT;
              end
              S_TRY1_WAIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_WAKE;
                seq_nxt = S_TRY2;
              end
              S_TRY2: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.retry_dly);
                res_cnt = 2'd1;
                seq_nxt = S_TRY2_WAIT;
              end
              S_TRY2_WAIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_WAKE;
                seq_nxt = S_TRY3;
              end
              S_TRY3: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00,
                            lcdseq_pkg::THIRD_WAIT_MS);
                res_cnt = 2'd1;
                seq_nxt = S_TRY3_WAIT;
              end
              S_TRY3_WAIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_4BIT;
                seq_nxt = S_TO4BIT;
              end
              S_TO4BIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_FUNC | {3'b000, cfg.func_flags};
                sw_two  = 1'b1;
                seq_nxt = S_FUNC;
              end
              S_FUNC: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_DISP | {5'b00000, cfg.disp_flags};
                sw_two  = 1'b1;
                seq_nxt = S_DISP;
              end
              S_DISP: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_CLEAR;
                sw_two  = 1'b1;
                seq_nxt = S_CLEAR;
              end
              S_CLEAR: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.clr_dly);
                res_cnt = 2'd1;
                seq_nxt = S_CLEAR_WAIT;
              end
              S_CLEAR_WAIT: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_ENTRY | {6'b000000, cfg.entry_flags};
                sw_two  = 1'b1;
                seq_nxt = S_ENTRY;
              end
              S_ENTRY: begin
                sw      = 1'b1;
                sw_b    = lcdseq_pkg::CMD_HOME;
                sw_two  = 1'b1;
                seq_nxt = S_HOME;
              end
              S_HOME: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.clr_dly);
                res_cnt = 2'd1;
                seq_nxt = S_HOME_WAIT;
              end
              S_HOME_WAIT: begin
                res0     = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_INIT_DONE, 8'h00, 16'd0);
                res_cnt  = 2'd1;
                init_nxt = 1'b1;
                seq_nxt  = S_IDLE;
                if (pv_r) begin
                  pv_nxt  = 1'b0;
                  pc_nxt  = 8'h00;
                  sw      = 1'b1;
                  sw_sec  = 1'b1;
                  sw_b    = pc_r;
                  sw_rs   = 1'b1;
                  sw_two  = 1'b1;
                  seq_nxt = S_CHAR;
                end
              end
              S_CHAR: begin
                res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_CHAR_DONE, 8'h00, 16'd0);
                res_cnt = 2'd1;
                seq_nxt = S_IDLE;
              end
              default: seq_nxt = S_IDLE;
            endcase
          end
        end
        lcdseq_pkg::OP_CHAR: begin
          if (seq_r != S_IDLE || ph_r != lcdseq_pkg::PH_NIL) begin
            res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_REJECT, 8'h00, 16'd0);
            res_cnt = 2'd1;
          end else if (!init_r) begin
            pv_nxt  = 1'b1;
            pc_nxt  = char_code;
            res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_DELAY, 8'h00, cfg.init_dly);
            res_cnt = 2'd1;
            seq_nxt = S_INIT_WAIT;
          end else begin
            sw      = 1'b1;
            sw_b    = char_code;
            sw_rs   = 1'b1;
            sw_two  = 1'b1;
            seq_nxt = S_CHAR;
          end
        end
        lcdseq_pkg::OP_BL: begin
          bl_nxt  = backlight_on;
          res0    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_BL_ACK, 8'h00, 16'd0);
          res_cnt = 2'd1;
        end
        default: ;
      endcase
    end

    // Starting a byte write emits its first nibble right away.
    if (sw) begin
      btw_nxt = sw_b;
      rs_nxt  = sw_rs;
      two_nxt = sw_two;
      ph_nxt  = lcdseq_pkg::PH_EN_HIGH;
      sres    = lcdseq_pkg::mk_res(lcdseq_pkg::ACT_SEND,
                  lcdseq_pkg::ctl_byte(lcdseq_pkg::nibble(sw_b, sw_two), bl_nxt, sw_rs),
                  16'd0);
      if (sw_sec) begin
        res1    = sres;
        res_cnt = 2'd2;
      end else begin
        res0    = sres;
        res_cnt = 2'd1;
      end
    end

    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end else if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= S_IDLE;
      ph_r   <= lcdseq_pkg::PH_NIL;
      two_r  <= 1'b0;
      btw_r  <= 8'h00;
      rs_r   <= 1'b0;
      init_r <= 1'b0;
      bl_r   <= 1'b0;
      pv_r   <= 1'b0;
      pc_r   <= 8'h00;
    end else begin
      seq_r  <= seq_nxt;
      ph_r   <= ph_nxt;
      two_r  <= two_nxt;
      btw_r  <= btw_nxt;
      rs_r   <= rs_nxt;
      init_r <= init_nxt;
      bl_r   <= bl_nxt;
      pv_r   <= pv_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lcdseq_outq.sv
// Result queue that takes up to two results per cycle and drains one per beat.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_outq (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  [1:0]               push_cnt,
  input  wire lcdseq_pkg::result_t push0,
  input  wire lcdseq_pkg::result_t push1,
  output logic                     room2,
  output logic                     head_valid,
  output lcdseq_pkg::result_t      head,
  input  wire                      pop
);

  lcdseq_pkg::result_t mem_r [lcdseq_pkg::QDepth];

  logic [lcdseq_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lcdseq_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lcdseq_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic [lcdseq_pkg::QAW-1:0] wr_ptr_p1;
  logic                       do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign wr_ptr_p1  = wr_ptr_r + lcdseq_pkg::QAW'(1);
  assign wr_ptr_nxt = wr_ptr_r + lcdseq_pkg::QAW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + lcdseq_pkg::QAW'(do_pop);
  assign cnt_nxt    = cnt_r + lcdseq_pkg::QCW'(push_cnt) - lcdseq_pkg::QCW'(do_pop);

  assign room2      = (cnt_r <= lcdseq_pkg::QCW'(lcdseq_pkg::QDepth - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_i2c_expander_sequencer_top.sv
// Top level of the character LCD expander sequencer.
//
// The in_ channel carries events: step done (a send or delay finished),
// write character and set backlight, with the opcode in in_tuser. For each
// beat the block produces zero, one or two result beats on the out_ channel:
// an expander byte to send, a delay to start, init complete, character
// written, backlight acknowledgment or rejection; out_tlast marks the last
// result of an input beat. Results are queued as their beat is accepted and
// reach out_ once earlier results have drained. The sequencer state updates
// on acceptance, so one input beat per cycle is taken while the four-entry
// result queue has room for two more results; results drain at one per beat.
// When the receiver stalls, the queue fills and in_tready drops until two
// entries are free again. Synchronous reset empties the queue, returns the
// sequencer to idle and uninitialized with backlight off, and loads the
// register defaults. Registers are written through cfg_we, cfg_index and
// cfg_wdata and should only change while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_i2c_expander_sequencer_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] char_code, [8] backlight_on, rest zero
  input  wire  [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] expander_byte, [23:8] delay_ms
  output logic [2:0]  out_tuser,  // [2:0] action
  output logic        out_tlast,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);

  lcdseq_pkg::cfg_t    cfg;
  lcdseq_pkg::result_t res0;
  lcdseq_pkg::result_t res1;
  lcdseq_pkg::result_t head;
  logic [1:0]          res_cnt;
  logic                room2;
  logic                in_fire;

  assign in_tready = room2;
  assign in_fire   = in_tvalid && room2;

  lcdseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .opcode       (in_tuser),
    .char_code    (in_tdata[7:0]),
    .backlight_on (in_tdata[8]),
    .cfg          (cfg),
    .res_cnt      (res_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  lcdseq_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (res_cnt),
    .push0      (res0),
    .push1      (res1),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {head.delay_ms, head.xbyte};
  assign out_tuser = head.action;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

>>> rtl/core/lcdseq_chk.sv
// Port-level checker for the character LCD expander sequencer and its bind.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire [2:0]  out_tuser,
  input wire        out_tlast
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset empties the result queue.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A send carries no delay and a delay carries no byte.
  a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lcdseq_pkg::ACT_SEND |-> out_tdata[23:8] == 16'd0)
    else $error("send beat with nonzero delay");

  a_delay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lcdseq_pkg::ACT_DELAY |-> out_tdata[7:0] == 8'd0)
    else $error("delay beat with nonzero byte");

  // Rejection, acknowledgment and character done always close their input's results.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == lcdseq_pkg::ACT_REJECT ||
                   out_tuser == lcdseq_pkg::ACT_BL_ACK ||
                   out_tuser == lcdseq_pkg::ACT_CHAR_DONE) |-> out_tlast)
    else $error("single result beat without last");

endmodule

bind char_lcd_i2c_expander_sequencer_top lcdseq_chk u_lcdseq_chk (.*);

`default_nettype wire

>>> dv/tb_char_lcd_i2c_expander_sequencer_top.sv
// Self-checking bench for the LCD expander sequencer: a directed table, then random streams.
`timescale 1ns / 1ps
module tb_char_lcd_i2c_expander_sequencer_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned BEATS_PER_SETTING = 325;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_INIT_WAIT, SQ_BL_SENT, SQ_BL_WAIT, SQ_TRY1, SQ_TRY1_WAIT, SQ_TRY2,
    SQ_TRY2_WAIT, SQ_TRY3, SQ_TRY3_WAIT, SQ_TO4BIT, SQ_FUNC, SQ_DISP, SQ_CLEAR,
    SQ_CLEAR_WAIT, SQ_ENTRY, SQ_HOME, SQ_HOME_WAIT, SQ_CHAR
  } lcd_seq_t;

  typedef enum int {SET_MAX, SET_ZERO, SET_RAND, SET_DEFAULT} reg_set_t;

  typedef struct packed {
    logic                drain;
    logic [1:0]          op;
    logic [7:0]          chr;
    logic                bl;
    logic                typed;
    logic                has_res;
    lcdseq_pkg::result_t res;
  } dir_row_t;

  localparam lcdseq_pkg::result_t NO_RES = '0;
  localparam lcdseq_pkg::result_t R_ACK  = '{lcdseq_pkg::ACT_BL_ACK, 8'h00, 16'd0, 1'b1};
  localparam lcdseq_pkg::result_t R_REJ  = '{lcdseq_pkg::ACT_REJECT, 8'h00, 16'd0, 1'b1};
  localparam lcdseq_pkg::result_t R_INIT = '{lcdseq_pkg::ACT_DELAY, 8'h00, 16'd50, 1'b1};
  localparam lcdseq_pkg::result_t R_BLON = '{lcdseq_pkg::ACT_SEND, 8'h08, 16'd0, 1'b1};
  localparam lcdseq_pkg::result_t R_BLDLY = '{lcdseq_pkg::ACT_DELAY, 8'h00, 16'd1000, 1'b1};
  localparam lcdseq_pkg::result_t R_WAKE = '{lcdseq_pkg::ACT_SEND, 8'h30, 16'd0, 1'b1};
  localparam lcdseq_pkg::result_t R_WKEN = '{lcdseq_pkg::ACT_SEND, 8'h3C, 16'd0, 1'b1};
  localparam lcdseq_pkg::result_t R_HOLD = '{lcdseq_pkg::ACT_DELAY, 8'h00, 16'd1, 1'b1};

  dir_row_t dir_tab [25] = '{
    '{1'b0, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, OP_UNUSED,           8'hFF, 1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_BL,   8'h00, 1'b0, 1'b1, 1'b1, R_ACK},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'hA5, 1'b0, 1'b1, 1'b1, R_INIT},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'h5A, 1'b1, 1'b1, 1'b1, R_REJ},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'hFF, 1'b1, 1'b1, 1'b1, R_BLON},
    '{1'b0, lcdseq_pkg::OP_BL,   8'hFF, 1'b0, 1'b1, 1'b1, R_ACK},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b1, 1'b1, R_BLDLY},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b1, 1'b1, R_WAKE},
    '{1'b0, lcdseq_pkg::OP_BL,   8'h00, 1'b1, 1'b1, 1'b1, R_ACK},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b1, 1'b1, R_WKEN},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b1, 1'b1, R_HOLD},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'h00, 1'b0, 1'b1, 1'b1, R_REJ},
    '{1'b1, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, OP_UNUSED,           8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b1, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'hFF, 1'b1, 1'b1, 1'b1, R_REJ},
    '{1'b1, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_BL,   8'h00, 1'b0, 1'b1, 1'b1, R_ACK},
    '{1'b0, lcdseq_pkg::OP_CHAR, 8'h81, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, lcdseq_pkg::OP_STEP, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, lcdseq_pkg::OP_BL,   8'h00, 1'b1, 1'b1, 1'b1, R_ACK},
    '{1'b0, lcdseq_pkg::OP_STEP, 8'hFF, 1'b1, 1'b1, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [15:0] in_tdata = 16'h0000;              // [7:0] char_code, [8] backlight_on, rest zero
  logic [1:0]  in_tuser = lcdseq_pkg::OP_STEP;   // [1:0] opcode
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [23:0] out_tdata;                        // [7:0] expander_byte, [23:8] delay_ms
  wire  [2:0]  out_tuser;                        // [2:0] action
  wire         out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = lcdseq_pkg::CFG_INIT_DLY;
  logic [15:0] cfg_wdata = 16'h0000;

  char_lcd_i2c_expander_sequencer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow of the sequencer state and its registers.
  lcdseq_pkg::cfg_t lcd_cfg;
  lcd_seq_t   seq_st;
  logic [2:0] wr_phase;
  logic       hi_pass_left;
  logic [7:0] wr_byte;
  logic       wr_rs;
  logic       lcd_ready;
  logic       bl_on;
  logic       pend_vld;
  logic [7:0] pend_chr;

  lcdseq_pkg::result_t beat_res [2];
  int                  beat_n;
  lcdseq_pkg::result_t lcd_actions_q [$];

  int unsigned cyc = 0;
  int n_beats = 0;
  int n_ignored = 0;
  int n_results = 0;
  int n_chars = 0;
  int n_rejects = 0;
  int n_bl_acks = 0;
  int n_cfg = 0;
  int n_errors = 0;
  bit no_idle = 1'b0;

  function automatic logic lcd_busy();
    return (seq_st != SQ_IDLE) || (wr_phase != lcdseq_pkg::PH_NIL);
  endfunction

  function automatic void add_result(logic [2:0] act, logic [7:0] b, logic [15:0] d);
    if (beat_n < 2) begin
      beat_res[beat_n] = '{act, b, d, 1'b0};
      beat_n++;
    end
  endfunction

  function automatic void add_xbyte(logic [7:0] v);
    add_result(lcdseq_pkg::ACT_SEND,
               v | (bl_on ? lcdseq_pkg::CTL_BL : 8'h00) | (wr_rs ? lcdseq_pkg::CTL_RS : 8'h00),
               16'd0);
  endfunction

  function automatic logic [7:0] cur_nibble();
    return hi_pass_left ? (wr_byte & lcdseq_pkg::NIB_MASK) : {wr_byte[3:0], 4'h0};
  endfunction

  function automatic void advance_nibble();
    case (wr_phase)
      lcdseq_pkg::PH_NIBBLE: begin
        add_xbyte(cur_nibble());
        wr_phase = lcdseq_pkg::PH_EN_HIGH;
      end
      lcdseq_pkg::PH_EN_HIGH: begin
        add_xbyte(cur_nibble() | lcdseq_pkg::CTL_EN);
        wr_phase = lcdseq_pkg::PH_HIGH_HOLD;
      end
      lcdseq_pkg::PH_HIGH_HOLD: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.hold_dly);
        wr_phase = lcdseq_pkg::PH_EN_LOW;
      end
      lcdseq_pkg::PH_EN_LOW: begin
        add_xbyte(cur_nibble());
        wr_phase = lcdseq_pkg::PH_LOW_HOLD;
      end
      lcdseq_pkg::PH_LOW_HOLD: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.hold_dly);
        wr_phase = hi_pass_left ? lcdseq_pkg::PH_NIBBLE : lcdseq_pkg::PH_NIL;
        hi_pass_left = 1'b0;
      end
      default: wr_phase = lcdseq_pkg::PH_NIL;
    endcase
  endfunction

  function automatic void begin_byte(logic [7:0] c, logic rs, logic two);
    wr_byte = c;
    wr_rs = rs;
    hi_pass_left = two;
    wr_phase = lcdseq_pkg::PH_NIBBLE;
    advance_nibble();
  endfunction

  function automatic void advance_power_up();
    case (seq_st)
      SQ_INIT_WAIT: begin
        bl_on = 1'b1;
        add_xbyte(8'h00);
        seq_st = SQ_BL_SENT;
      end
      SQ_BL_SENT: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.bl_dly);
        seq_st = SQ_BL_WAIT;
      end
      SQ_BL_WAIT: begin
        begin_byte(lcdseq_pkg::CMD_WAKE, 1'b0, 1'b0);
        seq_st = SQ_TRY1;
      end
      SQ_TRY1: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.retry_dly);
        seq_st = SQ_TRY1_WAIT;
      end
      SQ_TRY1_WAIT: begin
        begin_byte(lcdseq_pkg::CMD_WAKE, 1'b0, 1'b0);
        seq_st = SQ_TRY2;
      end
      SQ_TRY2: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.retry_dly);
        seq_st = SQ_TRY2_WAIT;
      end
      SQ_TRY2_WAIT: begin
        begin_byte(lcdseq_pkg::CMD_WAKE, 1'b0, 1'b0);
        seq_st = SQ_TRY3;
      end
      SQ_TRY3: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcdseq_pkg::THIRD_WAIT_MS);
        seq_st = SQ_TRY3_WAIT;
      end
      SQ_TRY3_WAIT: begin
        begin_byte(lcdseq_pkg::CMD_4BIT, 1'b0, 1'b0);
        seq_st = SQ_TO4BIT;
      end
      SQ_TO4BIT: begin
        begin_byte(lcdseq_pkg::CMD_FUNC | {3'b000, lcd_cfg.func_flags}, 1'b0, 1'b1);
        seq_st = SQ_FUNC;
      end
      SQ_FUNC: begin
        begin_byte(lcdseq_pkg::CMD_DISP | {5'b00000, lcd_cfg.disp_flags}, 1'b0, 1'b1);
        seq_st = SQ_DISP;
      end
      SQ_DISP: begin
        begin_byte(lcdseq_pkg::CMD_CLEAR, 1'b0, 1'b1);
        seq_st = SQ_CLEAR;
      end
      SQ_CLEAR: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.clr_dly);
        seq_st = SQ_CLEAR_WAIT;
      end
      SQ_CLEAR_WAIT: begin
        begin_byte(lcdseq_pkg::CMD_ENTRY | {6'b000000, lcd_cfg.entry_flags}, 1'b0, 1'b1);
        seq_st = SQ_ENTRY;
      end
      SQ_ENTRY: begin
        begin_byte(lcdseq_pkg::CMD_HOME, 1'b0, 1'b1);
        seq_st = SQ_HOME;
      end
      SQ_HOME: begin
        add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.clr_dly);
        seq_st = SQ_HOME_WAIT;
      end
      SQ_HOME_WAIT: begin
        add_result(lcdseq_pkg::ACT_INIT_DONE, 8'h00, 16'd0);
        lcd_ready = 1'b1;
        seq_st = SQ_IDLE;
        if (pend_vld) begin
          pend_vld = 1'b0;
          begin_byte(pend_chr, 1'b1, 1'b1);
          pend_chr = 8'h00;
          seq_st = SQ_CHAR;
        end
      end
      SQ_CHAR: begin
        seq_st = SQ_IDLE;
        add_result(lcdseq_pkg::ACT_CHAR_DONE, 8'h00, 16'd0);
      end
      default: seq_st = SQ_IDLE;
    endcase
  endfunction

  function automatic void predict_beat(logic [1:0] op, logic [7:0] c, logic b);
    beat_n = 0;
    case (op)
      lcdseq_pkg::OP_STEP: begin
        if (wr_phase != lcdseq_pkg::PH_NIL) advance_nibble();
        else if (seq_st != SQ_IDLE) advance_power_up();
      end
      lcdseq_pkg::OP_CHAR: begin
        if (lcd_busy()) begin
          add_result(lcdseq_pkg::ACT_REJECT, 8'h00, 16'd0);
        end else if (!lcd_ready) begin
          pend_vld = 1'b1;
          pend_chr = c;
          add_result(lcdseq_pkg::ACT_DELAY, 8'h00, lcd_cfg.init_dly);
          seq_st = SQ_INIT_WAIT;
        end else begin
          begin_byte(c, 1'b1, 1'b1);
          seq_st = SQ_CHAR;
        end
      end
      lcdseq_pkg::OP_BL: begin
        bl_on = b;
        add_result(lcdseq_pkg::ACT_BL_ACK, 8'h00, 16'd0);
      end
      default: ;
    endcase
    if (beat_n > 0) beat_res[beat_n - 1].last = 1'b1;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      lcdseq_pkg::CFG_INIT_DLY:    lcd_cfg.init_dly = v;
      lcdseq_pkg::CFG_BL_DLY:      lcd_cfg.bl_dly = v;
      lcdseq_pkg::CFG_RETRY_DLY:   lcd_cfg.retry_dly = v;
      lcdseq_pkg::CFG_CLR_DLY:     lcd_cfg.clr_dly = v;
      lcdseq_pkg::CFG_HOLD_DLY:    lcd_cfg.hold_dly = v;
      lcdseq_pkg::CFG_FUNC_FLAGS:  lcd_cfg.func_flags = v[4:0];
      lcdseq_pkg::CFG_DISP_FLAGS:  lcd_cfg.disp_flags = v[2:0];
      lcdseq_pkg::CFG_ENTRY_FLAGS: lcd_cfg.entry_flags = v[1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_beat(input logic [1:0] op, input logic [7:0] c, input logic b);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'b0000000, b, c};
    do @(posedge clk); while (!in_tready);
    predict_beat(op, c, b);
    n_beats++;
    if (beat_n == 0) n_ignored++;
  endtask

  task automatic queue_predicted();
    for (int i = 0; i < beat_n; i++) lcd_actions_q.push_back(beat_res[i]);
  endtask

  task automatic drain_busy();
    while (lcd_busy()) begin
      idle_gap(pick_gap());
      offer_beat(lcdseq_pkg::OP_STEP, 8'($urandom), 1'($urandom));
      queue_predicted();
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (lcd_actions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input reg_set_t mode);
    logic [15:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        SET_MAX:  v = 16'hFFFF;
        SET_ZERO: v = 16'h0000;
        SET_RAND: v = 16'($urandom);
        default: begin
          case (3'(i))
            lcdseq_pkg::CFG_INIT_DLY:   v = lcdseq_pkg::RST_INIT_DLY;
            lcdseq_pkg::CFG_BL_DLY:     v = lcdseq_pkg::RST_BL_DLY;
            lcdseq_pkg::CFG_RETRY_DLY:  v = lcdseq_pkg::RST_RETRY_DLY;
            lcdseq_pkg::CFG_CLR_DLY:    v = lcdseq_pkg::RST_CLR_DLY;
            lcdseq_pkg::CFG_HOLD_DLY:   v = lcdseq_pkg::RST_HOLD_DLY;
            lcdseq_pkg::CFG_FUNC_FLAGS: v = {11'd0, lcdseq_pkg::RST_FUNC_FLAGS};
            lcdseq_pkg::CFG_DISP_FLAGS: v = {13'd0, lcdseq_pkg::RST_DISP_FLAGS};
            default:                    v = {14'd0, lcdseq_pkg::RST_ENTRY_FLAGS};
          endcase
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= v;
      apply_reg(3'(i), v);
      n_cfg++;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 40)
      $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
               n_results, what, got, want);
  endtask

  always @(posedge clk) begin : out_check
    lcdseq_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser == lcdseq_pkg::ACT_CHAR_DONE) n_chars++;
      if (out_tuser == lcdseq_pkg::ACT_REJECT) n_rejects++;
      if (out_tuser == lcdseq_pkg::ACT_BL_ACK) n_bl_acks++;
      if (lcd_actions_q.size() == 0) begin
        report_mismatch("beat with nothing expected, action", out_tuser, 0);
      end else begin
        want = lcd_actions_q.pop_front();
        if (out_tuser !== want.action) report_mismatch("action", out_tuser, want.action);
        if (out_tdata[7:0] !== want.xbyte)
          report_mismatch("expander byte", out_tdata[7:0], want.xbyte);
        if (out_tdata[23:8] !== want.delay_ms)
          report_mismatch("delay", out_tdata[23:8], want.delay_ms);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cyc,
               lcd_actions_q.size());
      $display("char_lcd_i2c_expander_sequencer_top test failed");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off so the result queue backs up.
  initial begin : rx_side
    int r;
    int len;
    int rx_cycles;
    bit long_done;
    rx_cycles = 0;
    long_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 199);
      if (!long_done && rx_cycles > 2500) begin
        out_tready <= 1'b0;
        len = $urandom_range(150, 250);
        long_done = 1'b1;
      end else if (r < 100) begin
        out_tready <= 1'b1;
        len = $urandom_range(1, 10);
      end else if (r < 110) begin
        out_tready <= 1'b1;
        len = $urandom_range(30, 80);
      end else if (r < 190) begin
        out_tready <= 1'b0;
        len = $urandom_range(1, 3);
      end else if (r < 198) begin
        out_tready <= 1'b0;
        len = $urandom_range(8, 40);
      end else begin
        out_tready <= 1'b0;
        len = $urandom_range(80, 150);
      end
      repeat (len) @(posedge clk);
      rx_cycles += len;
    end
  end

  initial begin : tx_side
    reg_set_t settings [4];
    int counted;
    int r;
    logic [1:0] op;
    settings = '{SET_MAX, SET_ZERO, SET_RAND, SET_DEFAULT};
    lcd_cfg = '{lcdseq_pkg::RST_INIT_DLY, lcdseq_pkg::RST_BL_DLY, lcdseq_pkg::RST_RETRY_DLY,
                lcdseq_pkg::RST_CLR_DLY, lcdseq_pkg::RST_HOLD_DLY, lcdseq_pkg::RST_FUNC_FLAGS,
                lcdseq_pkg::RST_DISP_FLAGS, lcdseq_pkg::RST_ENTRY_FLAGS};
    seq_st = SQ_IDLE;
    wr_phase = lcdseq_pkg::PH_NIL;
    hi_pass_left = 1'b0;
    wr_byte = 8'h00;
    wr_rs = 1'b0;
    lcd_ready = 1'b0;
    bl_on = 1'b0;
    pend_vld = 1'b0;
    pend_chr = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: power-up with reset timing, rejections, backlight changes.
    foreach (dir_tab[k]) begin
      if (dir_tab[k].drain) begin
        drain_busy();
      end else begin
        idle_gap(pick_gap());
        offer_beat(dir_tab[k].op, dir_tab[k].chr, dir_tab[k].bl);
        if (!dir_tab[k].typed) queue_predicted();
        else if (dir_tab[k].has_res) lcd_actions_q.push_back(dir_tab[k].res);
      end
    end
    settle();

    // Random part: mostly complete character writes with noise mixed in.
    foreach (settings[p]) begin
      program_regs(settings[p]);
      no_idle = 1'b0;
      counted = 0;
      while (counted < BEATS_PER_SETTING) begin
        if ($urandom_range(0, 79) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 199) == 0) settle();
        r = $urandom_range(0, 99);
        if (lcd_busy()) begin
          if (r < 88) op = lcdseq_pkg::OP_STEP;
          else if (r < 93) op = lcdseq_pkg::OP_CHAR;
          else if (r < 97) op = lcdseq_pkg::OP_BL;
          else op = OP_UNUSED;
        end else begin
          if (r < 70) op = lcdseq_pkg::OP_CHAR;
          else if (r < 82) op = lcdseq_pkg::OP_BL;
          else if (r < 92) op = lcdseq_pkg::OP_STEP;
          else op = OP_UNUSED;
        end
        idle_gap(pick_gap());
        offer_beat(op, 8'($urandom), 1'($urandom));
        queue_predicted();
        if (beat_n > 0) counted++;
      end
      drain_busy();
      settle();
    end

    repeat (10) @(posedge clk);
    $display("Covered power-up, %0d characters written, %0d rejected writes, %0d backlight acks.",
             n_chars, n_rejects, n_bl_acks);
    $display("Checked %0d results from %0d input beats (%0d ignored), %0d register writes.",
             n_results, n_beats, n_ignored, n_cfg);
    if (n_errors == 0) begin
      $display("char_lcd_i2c_expander_sequencer_top test passed");
    end else begin
      $display("char_lcd_i2c_expander_sequencer_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_cfg.sv
rtl/core/lcdseq_core.sv
rtl/core/lcdseq_outq.sv
rtl/core/char_lcd_i2c_expander_sequencer_top.sv
rtl/core/lcdseq_chk.sv
dv/tb_char_lcd_i2c_expander_sequencer_top.sv
